/* src/ppcm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the peak-to-peak current monitor.
package ppcm_pkg;

	localparam int unsigned ADC_BITS_DEF   = 12;
	localparam int unsigned MAX_WINDOW_DEF = 4096;

	localparam int unsigned WLEN_W   = 13;
	localparam int unsigned GAIN_W   = 24;
	localparam int unsigned LIMIT_W  = 16;
	localparam int unsigned OUT_W    = 16;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned FRAC_W   = 16;

	localparam logic [WLEN_W-1:0]  WLEN_RST       = WLEN_W'(1024);
	localparam logic [GAIN_W-1:0]  PEAK_GAIN_RST  = GAIN_W'(264045);
	localparam logic [GAIN_W-1:0]  RMS_GAIN_RST   = GAIN_W'(186708);
	localparam logic [LIMIT_W-1:0] LIMIT_RST      = LIMIT_W'(10000);

	typedef enum logic [1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_PEAK_GAIN     = 2'd1,
		CFG_RMS_GAIN      = 2'd2,
		CFG_CURRENT_LIMIT = 2'd3
	} cfg_index_t;

endpackage

/* src/ppcm_sample_if.sv */
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake carrying one converter reading.
interface ppcm_sample_if #(
	parameter int unsigned ADC_BITS = ppcm_pkg::ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* src/ppcm_result_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one window measurement.
interface ppcm_result_if;
	logic                          valid;
	logic                          ready;
	logic [ppcm_pkg::OUT_W-1:0]    rms_ma;
	logic [ppcm_pkg::OUT_W-1:0]    peak_ma;
	logic                          current_ok;

	modport source (output valid, output rms_ma, output peak_ma, output current_ok, input ready);
	modport sink   (input valid, input rms_ma, input peak_ma, input current_ok, output ready);
endinterface

/* src/peak_to_peak_current_monitor_unit.sv */
`timescale 1ns / 1ps
// Top level of the peak-to-peak current monitor.
//
// Usage:
//   sample_ch takes raw converter readings, one transfer per sample. Each
//   sample updates the running window maximum, minimum and count. When the
//   count reaches window_length (0 acts as 1, capped at MAX_WINDOW) the
//   window closes: the swing goes down a three-register pipeline and one
//   transfer on result_ch gives rms_ma, peak_ma (swing times gain, Q8.16,
//   rounded half up, saturated to 65535) and current_ok (rms_ma < limit).
//   A new window starts with the next sample.
// Pipeline and throughput:
//   One sample per cycle while sample_ch.ready is high. A result comes from the
//   window's last sample through the swing, product and output registers, in order.
//   The two 24-bit gain multipliers sit alone in the middle stage.
// Stall:
//   Every stage advances when the one after it is empty or moving, so
//   sample_ch.ready drops only while all three stages hold results and
//   result_ch is stalled. Nothing is lost or repeated.
// Reset:
//   arst_n clears the pipeline, restarts the window and loads the default
//   register values. Configuration goes through cfg_we/cfg_index/cfg_data;
//   the user must write it only while the block is idle; the block lacks a check.
module peak_to_peak_current_monitor_unit #(
	parameter int unsigned ADC_BITS   = ppcm_pkg::ADC_BITS_DEF,
	parameter int unsigned MAX_WINDOW = ppcm_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  ppcm_pkg::cfg_index_t         cfg_index,
	input  logic [ppcm_pkg::CFG_W-1:0]   cfg_data,
	ppcm_sample_if.sink                  sample_ch,
	ppcm_result_if.source                result_ch
);
	import ppcm_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int unsigned EW     = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int unsigned PROD_W = ADC_BITS + GAIN_W;
	localparam int unsigned SUM_W  = PROD_W + 1;
	localparam int unsigned SH_W   = SUM_W - FRAC_W;

	// Round half up, drop the fraction, saturate to the output width.
	function automatic logic [OUT_W-1:0] round_sat(input logic [PROD_W-1:0] prod);
		logic [SUM_W-1:0] sum;
		logic [SH_W-1:0]  whole;
		sum   = {1'b0, prod} + SUM_W'(1 << (FRAC_W - 1));
		whole = sum[SUM_W-1:FRAC_W];
		if (|whole[SH_W-1:OUT_W]) begin
			return {OUT_W{1'b1}};
		end
		return whole[OUT_W-1:0];
	endfunction

	// Configuration registers
	logic [WLEN_W-1:0]  window_length_q;
	logic [GAIN_W-1:0]  peak_gain_q;
	logic [GAIN_W-1:0]  rms_gain_q;
	logic [LIMIT_W-1:0] current_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WLEN_RST;
			peak_gain_q     <= PEAK_GAIN_RST;
			rms_gain_q      <= RMS_GAIN_RST;
			current_limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[WLEN_W-1:0];
				CFG_PEAK_GAIN:     peak_gain_q     <= cfg_data[GAIN_W-1:0];
				CFG_RMS_GAIN:      rms_gain_q      <= cfg_data[GAIN_W-1:0];
				CFG_CURRENT_LIMIT: current_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: each stage moves when its successor has room.
	logic v_s1, v_s2, out_valid_q;
	logic adv1, adv2, adv3;
	logic accept;

	assign adv3   = !out_valid_q || result_ch.ready;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign sample_ch.ready = adv1;
	assign accept = sample_ch.valid && adv1;

	// Window tracking
	logic [CNT_W-1:0]    count_q, count_nxt;
	logic [ADC_BITS-1:0] max_q, min_q, max_nxt, min_nxt;
	logic [EW-1:0]       wlen_ext, eff_window;
	logic                close;

	assign wlen_ext = EW'(window_length_q);

	always_comb begin
		priority if (wlen_ext == '0) begin
			eff_window = EW'(1);
		end else if (wlen_ext > EW'(MAX_WINDOW)) begin
			eff_window = EW'(MAX_WINDOW);
		end else begin
			eff_window = wlen_ext;
		end
	end

	// Count stays below the effective window before increment, so no wrap.
	assign count_nxt = count_q + CNT_W'(1);
	assign max_nxt   = (sample_ch.sample > max_q) ? sample_ch.sample : max_q;
	assign min_nxt   = (sample_ch.sample < min_q) ? sample_ch.sample : min_q;
	assign close     = EW'(count_nxt) >= eff_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= '1;
		end else if (accept) begin
			if (close) begin
				count_q <= '0;
				max_q   <= '0;
				min_q   <= '1;
			end else begin
				count_q <= count_nxt;
				max_q   <= max_nxt;
				min_q   <= min_nxt;
			end
		end
	end

	// Stage 1: swing of the closed window
	logic [ADC_BITS-1:0] swing_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept && close;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && accept && close) begin
			swing_s1 <= (max_nxt >= min_nxt) ? (max_nxt - min_nxt) : '0;
		end
	end

	// Stage 2: gain products
	logic [PROD_W-1:0] rms_prod_s2, peak_prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rms_prod_s2  <= PROD_W'(swing_s1) * PROD_W'(rms_gain_q);
			peak_prod_s2 <= PROD_W'(swing_s1) * PROD_W'(peak_gain_q);
		end
	end

	// Stage 3: round, saturate, limit check into the output register
	logic [OUT_W-1:0] rms_rnd, peak_rnd;
	logic [OUT_W-1:0] rms_ma_q, peak_ma_q;
	logic             current_ok_q;

	assign rms_rnd  = round_sat(rms_prod_s2);
	assign peak_rnd = round_sat(peak_prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			rms_ma_q     <= rms_rnd;
			peak_ma_q    <= peak_rnd;
			current_ok_q <= rms_rnd < current_limit_q;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.rms_ma     = rms_ma_q;
	assign result_ch.peak_ma    = peak_ma_q;
	assign result_ch.current_ok = current_ok_q;

endmodule
